// ----- src/bicr_pkg.sv -----
// ----------------------------------------------------------------------------
// bicr_pkg
// Types, constants and the fractional exponential table for the Boltzmann
// ion count reduction core.
// ----------------------------------------------------------------------------
package bicr_pkg;

	localparam int unsigned NREG    = 8;
	localparam int unsigned ADDR_W  = 6;
	localparam int unsigned DATA_W  = 64;
	localparam int unsigned WGT_W   = 40;
	localparam int unsigned VAL_W   = 4;
	localparam int unsigned MANT_W  = 34;

	localparam logic [63:0] E_Q32    = 64'd11674931555;
	localparam logic [63:0] EINV_Q32 = 64'd1580030169;

	typedef enum logic [2:0] {
		REG_VAL_A  = 3'd0,
		REG_VAL_B  = 3'd1,
		REG_VAL_C  = 3'd2,
		REG_VAL_D  = 3'd3,
		REG_WGT_A  = 3'd4,
		REG_WGT_B  = 3'd5,
		REG_WGT_C  = 3'd6,
		REG_WGT_D  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MUL_EXP  = 2'd0,
		MUL_TOT  = 2'd1,
		MUL_BULK = 2'd2
	} mul_mode_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_EXP,
		C_EXP_W,
		C_ADD,
		C_TOT,
		C_TOT_W,
		C_BULK,
		C_BULK_W,
		C_EXCESS
	} cell_state_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_WAIT,
		T_EMIT
	} top_state_t;

	typedef struct packed {
		logic        vld;
		logic [15:0] pot;
		logic        acc;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [63:0] total;
		logic [63:0] bulk;
		logic [63:0] excess;
	} res_t;

	typedef logic [MANT_W-1:0] frac_tab_t [256];

	// e^(f/256) in Q32, twelfth-order series, truncating at every step
	function automatic frac_tab_t build_frac_tab();
		frac_tab_t   tab;
		logic [63:0] term;
		logic [63:0] m;
		logic [63:0] f;
		for (int i = 0; i < 256; i++) begin
			f    = 64'(i);
			term = 64'd1 << 32;
			m    = term;
			term = ((term * f) >> 8) / 1;  m = m + term;
			term = ((term * f) >> 8) / 2;  m = m + term;
			term = ((term * f) >> 8) / 3;  m = m + term;
			term = ((term * f) >> 8) / 4;  m = m + term;
			term = ((term * f) >> 8) / 5;  m = m + term;
			term = ((term * f) >> 8) / 6;  m = m + term;
			term = ((term * f) >> 8) / 7;  m = m + term;
			term = ((term * f) >> 8) / 8;  m = m + term;
			term = ((term * f) >> 8) / 9;  m = m + term;
			term = ((term * f) >> 8) / 10; m = m + term;
			term = ((term * f) >> 8) / 11; m = m + term;
			term = ((term * f) >> 8) / 12; m = m + term;
			tab[i] = m[MANT_W-1:0];
		end
		return tab;
	endfunction

	localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

// ----- src/bicr_if.sv -----
// ----------------------------------------------------------------------------
// bicr_in_if / bicr_out_if
// Valid/ready channels for grid points and species results.
// ----------------------------------------------------------------------------
interface bicr_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] potential;
	logic [15:0] accessibility;
	logic        last_point;
	modport source (output valid, potential, accessibility, last_point, input ready);
	modport sink (input valid, potential, accessibility, last_point, output ready);
endinterface

interface bicr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  species_index;
	logic [63:0] total_ions;
	logic [63:0] bulk_ions;
	logic [63:0] excess_ions;
	logic        last_result;
	modport source (output valid, species_index, total_ions, bulk_ions, excess_ions,
		last_result, input ready);
	modport sink (input valid, species_index, total_ions, bulk_ions, excess_ions,
		last_result, output ready);
endinterface

// ----- src/boltzmann_ion_count_reduction_core.sv -----
// Per point: cell g runs |k_g| multiplies by e or 1/e after its table lookup,
//   k_g = floor(arg/256) in [-16,15]; each cell sees a point in the cycle after
//   the cell before it along the chain.
// Throughput: one point at a time; the last point adds two multiplies and the
//   excess step per cell, then one result per cycle while the sink is ready.
// Reset: asynchronous active low; sums, count and registers return to defaults.
// ----------------------------------------------------------------------------
// boltzmann_ion_count_reduction_core
// Top level: APB register file, point count, chain of species cells and
// result sequencing.
// ----------------------------------------------------------------------------
module boltzmann_ion_count_reduction_core #(
	parameter int unsigned SPECIES         = 4,
	parameter int unsigned MAX_POINTS_LOG2 = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	bicr_in_if.sink     point,
	bicr_out_if.source  result
);

	localparam int unsigned NSP    = (SPECIES < 4) ? SPECIES : 4;
	localparam int unsigned CNT_W  = MAX_POINTS_LOG2 + 1;
	localparam int unsigned IDX_W  = (NSP > 1) ? $clog2(NSP) : 1;
	localparam int unsigned WAIT_N = NSP + 2;
	localparam int unsigned WAIT_W = $clog2(WAIT_N + 1);

	logic signed [3:0] val_q [4];
	logic [39:0]       wgt_q [4];

	bicr_pkg::top_state_t state_q, state_d;
	logic [CNT_W-1:0]     count_q, count_new;
	logic [WAIT_W-1:0]    wait_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 last_q;
	bicr_pkg::tok_t       tok0_q;
	logic [CNT_W-1:0]     cnt0_q;

	bicr_pkg::tok_t       tok  [NSP+1];
	logic [CNT_W-1:0]     cnt  [NSP+1];
	bicr_pkg::res_t       res  [NSP];
	logic [NSP-1:0]       idle;

	logic in_acc, out_acc, wr, idx_end;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign ridx   = paddr[5:3];

	always_comb begin
		case (ridx)
			bicr_pkg::REG_VAL_A: prdata = 64'(val_q[0]);
			bicr_pkg::REG_VAL_B: prdata = 64'(val_q[1]);
			bicr_pkg::REG_VAL_C: prdata = 64'(val_q[2]);
			bicr_pkg::REG_VAL_D: prdata = 64'(val_q[3]);
			bicr_pkg::REG_WGT_A: prdata = 64'(wgt_q[0]);
			bicr_pkg::REG_WGT_B: prdata = 64'(wgt_q[1]);
			bicr_pkg::REG_WGT_C: prdata = 64'(wgt_q[2]);
			default:             prdata = 64'(wgt_q[3]);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q[0] <= 4'sd1;
			val_q[1] <= -4'sd1;
			val_q[2] <= 4'sd0;
			val_q[3] <= 4'sd0;
			for (int i = 0; i < 4; i++)
				wgt_q[i] <= '0;
		end else if (wr) begin
			if (!ridx[2])
				val_q[ridx[1:0]] <= pwdata[3:0];
			else
				wgt_q[ridx[1:0]] <= pwdata[39:0];
		end
	end

	assign in_acc    = point.valid && point.ready;
	assign out_acc   = result.valid && result.ready;
	assign idx_end   = (idx_q == IDX_W'(NSP - 1));
	assign count_new = (point.accessibility != 16'd0 && count_q != '1) ?
		count_q + CNT_W'(1) : count_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bicr_pkg::T_IDLE:
				if (in_acc) state_d = bicr_pkg::T_WAIT;
			bicr_pkg::T_WAIT:
				if (wait_q == WAIT_W'(WAIT_N) && (&idle))
					state_d = last_q ? bicr_pkg::T_EMIT : bicr_pkg::T_IDLE;
			bicr_pkg::T_EMIT:
				if (out_acc && idx_end) state_d = bicr_pkg::T_IDLE;
			default:
				state_d = bicr_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		point.ready          = (state_q == bicr_pkg::T_IDLE);
		result.valid         = (state_q == bicr_pkg::T_EMIT);
		result.species_index = 2'(idx_q);
		result.total_ions    = res[idx_q].total;
		result.bulk_ions     = res[idx_q].bulk;
		result.excess_ions   = res[idx_q].excess;
		result.last_result   = idx_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bicr_pkg::T_IDLE;
			count_q <= '0;
			wait_q  <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
			tok0_q  <= '0;
			cnt0_q  <= '0;
		end else begin
			state_q    <= state_d;
			tok0_q.vld <= in_acc;
			if (in_acc) begin
				tok0_q.pot  <= point.potential;
				tok0_q.acc  <= (point.accessibility != 16'd0);
				tok0_q.last <= point.last_point;
				cnt0_q      <= count_new;
				count_q     <= point.last_point ? '0 : count_new;
				last_q      <= point.last_point;
				wait_q      <= '0;
				idx_q       <= '0;
			end else if (state_q == bicr_pkg::T_WAIT && wait_q != WAIT_W'(WAIT_N)) begin
				wait_q <= wait_q + WAIT_W'(1);
			end
			if (out_acc && !idx_end)
				idx_q <= idx_q + IDX_W'(1);
		end
	end

	assign tok[0] = tok0_q;
	assign cnt[0] = cnt0_q;

	for (genvar g = 0; g < NSP; g++) begin : g_cell
		bicr_cell #(.CNT_W(CNT_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valence (val_q[g]),
			.weight  (wgt_q[g]),
			.tok_in  (tok[g]),
			.cnt_in  (cnt[g]),
			.tok_out (tok[g+1]),
			.cnt_out (cnt[g+1]),
			.res     (res[g]),
			.idle    (idle[g])
		);
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(point.ready && result.valid))
		else $error("input ready while results pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !point.ready)
		else $error("second point taken while first in flight");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && result.last_result) |=> point.ready)
		else $error("block not ready after final result");

	a_emit_cells_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (&idle))
		else $error("result shown while a cell is busy");

endmodule

// ----- src/bicr_mul.sv -----
// ----------------------------------------------------------------------------
// bicr_mul
// Sequential 64x64 multiplier from 32x32 partial products, with
// round-half-up right shift and saturation to 64 bits.
// ----------------------------------------------------------------------------
module bicr_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bicr_pkg::mul_mode_t mode,
	input  logic [63:0]         a,
	input  logic [63:0]         b,
	output logic                done,
	output logic [63:0]         result
);

	logic [63:0]         a_q, b_q;
	bicr_pkg::mul_mode_t mode_q;
	logic [2:0]          cnt_q;
	logic                run_q;
	logic [63:0]         pp_q;
	logic [1:0]          off_q;
	logic                ppv_q;
	logic [127:0]        acc_q;
	logic                done_q;
	logic [63:0]         res_q;

	logic [31:0]  a_part, b_part;
	logic [127:0] rnd, shf;

	assign a_part = cnt_q[0] ? a_q[63:32] : a_q[31:0];
	assign b_part = cnt_q[1] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (mode_q)
			bicr_pkg::MUL_EXP: begin
				rnd = acc_q + (128'd1 << 31);
				shf = rnd >> 32;
			end
			bicr_pkg::MUL_TOT: begin
				rnd = acc_q + (128'd1 << 23);
				shf = rnd >> 24;
			end
			default: begin
				rnd = acc_q + (128'd1 << 7);
				shf = rnd >> 8;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			ppv_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				ppv_q <= 1'b0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				ppv_q <= !cnt_q[2];
				if (cnt_q == 3'd5) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= b;
			mode_q <= mode;
			acc_q  <= '0;
		end else if (run_q) begin
			if (!cnt_q[2]) begin
				pp_q  <= 64'(a_part) * 64'(b_part);
				off_q <= 2'(cnt_q[0]) + 2'(cnt_q[1]);
			end
			if (ppv_q)
				acc_q <= acc_q + ({64'd0, pp_q} << (7'd32 * 7'(off_q)));
			if (cnt_q == 3'd5)
				res_q <= (|shf[127:64]) ? '1 : shf[63:0];
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- src/bicr_cell.sv -----
// ----------------------------------------------------------------------------
// bicr_cell
// One species cell: Boltzmann factor, running sum and final scaling. The
// grid point token moves on to the neighbor cell in the next cycle.
// ----------------------------------------------------------------------------
module bicr_cell #(
	parameter int unsigned CNT_W = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [3:0]  valence,
	input  logic [39:0]        weight,
	input  bicr_pkg::tok_t     tok_in,
	input  logic [CNT_W-1:0]   cnt_in,
	output bicr_pkg::tok_t     tok_out,
	output logic [CNT_W-1:0]   cnt_out,
	output bicr_pkg::res_t     res,
	output logic               idle
);

	bicr_pkg::cell_state_t state_q, state_d;
	bicr_pkg::tok_t        tok_q;
	logic [CNT_W-1:0]      cnt_q, count_q;
	logic                  last_q, kneg_q;
	logic [4:0]            steps_q;
	logic [63:0]           m_q, sum_q;
	bicr_pkg::res_t        res_q;

	logic                  mul_start, mul_done;
	bicr_pkg::mul_mode_t   mul_mode;
	logic [63:0]           mul_a, mul_b, mul_res;

	logic signed [20:0]    arg, arg_sat;
	logic [12:0]           u;
	logic [63:0]           eq16;
	logic [64:0]           s_add;
	logic [63:0]           d_pos, d_neg;

	always_comb begin
		arg = -(21'(valence) * 21'($signed(tok_in.pot)));
		if (arg < -21'sd4096)
			arg_sat = -21'sd4096;
		else if (arg > 21'sd4095)
			arg_sat = 21'sd4095;
		else
			arg_sat = arg;
		u = 13'(arg_sat + 21'sd4096);
	end

	assign eq16  = (m_q + 64'd32768) >> 16;
	assign s_add = {1'b0, sum_q} + {1'b0, eq16};
	assign d_pos = res_q.total - res_q.bulk;
	assign d_neg = res_q.bulk - res_q.total;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bicr_pkg::C_IDLE: begin
				if (tok_in.vld && tok_in.acc)
					state_d = bicr_pkg::C_EXP;
				else if (tok_in.vld && tok_in.last)
					state_d = bicr_pkg::C_TOT;
			end
			bicr_pkg::C_EXP:
				state_d = (steps_q == 5'd0) ? bicr_pkg::C_ADD : bicr_pkg::C_EXP_W;
			bicr_pkg::C_EXP_W:
				if (mul_done) state_d = bicr_pkg::C_EXP;
			bicr_pkg::C_ADD:
				state_d = last_q ? bicr_pkg::C_TOT : bicr_pkg::C_IDLE;
			bicr_pkg::C_TOT:
				state_d = bicr_pkg::C_TOT_W;
			bicr_pkg::C_TOT_W:
				if (mul_done) state_d = bicr_pkg::C_BULK;
			bicr_pkg::C_BULK:
				state_d = bicr_pkg::C_BULK_W;
			bicr_pkg::C_BULK_W:
				if (mul_done) state_d = bicr_pkg::C_EXCESS;
			bicr_pkg::C_EXCESS:
				state_d = bicr_pkg::C_IDLE;
			default:
				state_d = bicr_pkg::C_IDLE;
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		mul_mode  = bicr_pkg::MUL_EXP;
		mul_a     = m_q;
		mul_b     = kneg_q ? bicr_pkg::EINV_Q32 : bicr_pkg::E_Q32;
		case (state_q)
			bicr_pkg::C_EXP:
				mul_start = (steps_q != 5'd0);
			bicr_pkg::C_TOT: begin
				mul_start = 1'b1;
				mul_mode  = bicr_pkg::MUL_TOT;
				mul_a     = sum_q;
				mul_b     = 64'(weight);
			end
			bicr_pkg::C_BULK: begin
				mul_start = 1'b1;
				mul_mode  = bicr_pkg::MUL_BULK;
				mul_a     = 64'(count_q);
				mul_b     = 64'(weight);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bicr_pkg::C_IDLE;
			tok_q   <= '0;
			sum_q   <= '0;
		end else begin
			state_q <= state_d;
			tok_q   <= tok_in;
			if (state_q == bicr_pkg::C_ADD)
				sum_q <= s_add[64] ? '1 : s_add[63:0];
			else if (state_q == bicr_pkg::C_EXCESS)
				sum_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q <= cnt_in;
		if (state_q == bicr_pkg::C_IDLE && tok_in.vld) begin
			last_q  <= tok_in.last;
			count_q <= cnt_in;
			m_q     <= 64'(bicr_pkg::FRAC_TAB[u[7:0]]);
			kneg_q  <= !u[12];
			steps_q <= u[12] ? 5'(u[11:8]) : 5'd16 - 5'(u[11:8]);
		end
		if (state_q == bicr_pkg::C_EXP_W && mul_done) begin
			m_q     <= mul_res;
			steps_q <= steps_q - 5'd1;
		end
		if (state_q == bicr_pkg::C_TOT_W && mul_done)
			res_q.total <= mul_res;
		if (state_q == bicr_pkg::C_BULK_W && mul_done)
			res_q.bulk <= mul_res;
		if (state_q == bicr_pkg::C_EXCESS) begin
			if (res_q.total >= res_q.bulk)
				res_q.excess <= d_pos[63] ? 64'h7FFF_FFFF_FFFF_FFFF : d_pos;
			else
				res_q.excess <= d_neg[63] ? 64'h8000_0000_0000_0000 : (~d_neg + 64'd1);
		end
	end

	bicr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mode   (mul_mode),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	assign tok_out = tok_q;
	assign cnt_out = cnt_q;
	assign res     = res_q;
	assign idle    = (state_q == bicr_pkg::C_IDLE);

endmodule

// ----- tb/sv/bicr_checker.sv -----
// ----------------------------------------------------------------------------
// bicr_checker
// Monitors the grid point, result and register channels of the ion count
// core. It keeps its own copy of the valences, weights, sums and point count,
// and predicts the species results for every accepted last grid point. Each
// accepted result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bicr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	bicr_in_if          point,
	bicr_out_if         result,
	output int          errors,
	output int          pending,
	output int          checked
);

	localparam logic [63:0] COUNT_SAT = (64'd1 << 25) - 64'd1;

	typedef struct {
		logic [1:0]  species;
		logic [63:0] total;
		logic [63:0] bulk;
		logic [63:0] excess;
		logic        last;
	} ion_result_t;

	ion_result_t        ion_results_q[$];
	logic signed [3:0]  valence[4];
	logic [39:0]        weight[4];
	logic [63:0]        bz_sum[4];
	logic [63:0]        acc_count;

	assign pending = ion_results_q.size();

	function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b} + (128'd1 << (s - 1));
		p = p >> s;
		return (p[127:64] != 0) ? '1 : p[63:0];
	endfunction

	function automatic logic [63:0] boltz_exp(int a);
		int          u;
		int          k;
		logic [63:0] f;
		logic [63:0] term;
		logic [63:0] m;
		u    = a + 4096;
		k    = (u >> 8) - 16;
		f    = 64'(u & 255);
		term = 64'd1 << 32;
		m    = term;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * f) >> 8) / n;
			m    = m + term;
		end
		for (int i = 0; i < k; i++)
			m = mul_round(m, bicr_pkg::E_Q32, 32);
		for (int i = 0; i > k; i--)
			m = mul_round(m, bicr_pkg::EINV_Q32, 32);
		return (m + 64'd32768) >> 16;
	endfunction

	task automatic take_point(logic [15:0] pot_raw, logic [15:0] acc, logic last);
		int          pot;
		int          a;
		logic [63:0] e;
		logic [63:0] s;
		logic [63:0] d;
		ion_result_t r;
		pot = $signed(pot_raw);
		if (acc != 0) begin
			for (int sp = 0; sp < 4; sp++) begin
				a = -int'(valence[sp]) * pot;
				if (a < -4096) a = -4096;
				if (a > 4095) a = 4095;
				e = boltz_exp(a);
				s = bz_sum[sp] + e;
				bz_sum[sp] = (s < e) ? '1 : s;
			end
			if (acc_count < COUNT_SAT)
				acc_count = acc_count + 1;
		end
		if (last) begin
			for (int sp = 0; sp < 4; sp++) begin
				r.species = 2'(sp);
				r.total   = mul_round(bz_sum[sp], {24'd0, weight[sp]}, 24);
				r.bulk    = mul_round(acc_count, {24'd0, weight[sp]}, 8);
				if (r.total >= r.bulk) begin
					d        = r.total - r.bulk;
					r.excess = d[63] ? 64'h7FFF_FFFF_FFFF_FFFF : d;
				end else begin
					d        = r.bulk - r.total;
					r.excess = d[63] ? 64'h8000_0000_0000_0000 : (~d + 64'd1);
				end
				r.last = (sp == 3);
				ion_results_q.push_back(r);
			end
			for (int sp = 0; sp < 4; sp++)
				bz_sum[sp] = '0;
			acc_count = '0;
		end
	endtask

	task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	initial begin
		errors  = 0;
		checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		ion_result_t         r;
		bicr_pkg::reg_idx_t  idx;
		if (!arst_n) begin
			valence = '{4'sd1, -4'sd1, 4'sd0, 4'sd0};
			for (int i = 0; i < 4; i++) begin
				weight[i] = '0;
				bz_sum[i] = '0;
			end
			acc_count = '0;
			ion_results_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				idx = bicr_pkg::reg_idx_t'(paddr[5:3]);
				case (idx)
					bicr_pkg::REG_VAL_A, bicr_pkg::REG_VAL_B,
					bicr_pkg::REG_VAL_C, bicr_pkg::REG_VAL_D: begin
						valence[idx] = pwdata[3:0];
					end
					default: begin
						weight[idx - bicr_pkg::REG_WGT_A] = pwdata[39:0];
					end
				endcase
			end
			if (result.valid && result.ready) begin
				if (ion_results_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual species %0d",
						$time, result.species_index);
					errors++;
				end else begin
					r = ion_results_q.pop_front();
					compare_field("species_index", 64'(r.species), 64'(result.species_index));
					compare_field("total_ions", r.total, result.total_ions);
					compare_field("bulk_ions", r.bulk, result.bulk_ions);
					compare_field("excess_ions", r.excess, result.excess_ions);
					compare_field("last_result", 64'(r.last), 64'(result.last_result));
					checked++;
				end
			end
			if (point.valid && point.ready)
				take_point(point.potential, point.accessibility, point.last_point);
		end
	end

endmodule

// ----- tb/sv/boltzmann_ion_count_reduction_core_test.sv -----
// ----------------------------------------------------------------------------
// boltzmann_ion_count_reduction_core_test
// Stimulus and verdict for the ion count core. Streams short grids of points
// under several register settings and three handshake mixes, including a long
// result hold-off that backs up the input; the checker does the comparison.
// ----------------------------------------------------------------------------
module boltzmann_ion_count_reduction_core_test;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	int          errors;
	int          pending;
	int          checked;
	int          snd_idle;
	int          rcv_stall;
	logic        hold_req;
	int          n_points;
	int          n_grids;
	int          n_settings;

	bicr_in_if  point ();
	bicr_out_if result ();

	boltzmann_ion_count_reduction_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.point   (point.sink),
		.result  (result.source)
	);

	bicr_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.point   (point),
		.result  (result),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#20000000;
		$display("tb: failure");
		$finish;
	end

	// result side: random stall, plus one long hold-off on request
	always @(posedge clk) begin
		int hold;
		if (hold_req) begin
			hold_req = 1'b0;
			hold     = 600;
		end
		if (hold > 0) begin
			hold--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= rcv_stall);
		end
	end

	task automatic reg_write(bicr_pkg::reg_idx_t idx, logic [63:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_species(int sp, int val, logic [63:0] wgt, logic [63:0] junk);
		reg_write(bicr_pkg::reg_idx_t'(bicr_pkg::REG_VAL_A + sp), {junk[63:4], 4'(val)});
		reg_write(bicr_pkg::reg_idx_t'(bicr_pkg::REG_WGT_A + sp), {junk[63:40], wgt[39:0]});
	endtask

	task automatic send_point(logic [15:0] pot, logic [15:0] acc, logic last);
		while ($urandom_range(99) < snd_idle) begin
			point.valid <= 1'b0;
			@(posedge clk);
		end
		point.valid         <= 1'b1;
		point.potential     <= pot;
		point.accessibility <= acc;
		point.last_point    <= last;
		@(negedge clk);
		while (!point.ready) @(negedge clk);
		@(posedge clk);
		n_points++;
		if (last) n_grids++;
	endtask

	task automatic drain();
		@(posedge clk);
		point.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_pot();
		int c;
		c = $urandom_range(99);
		if (c < 65) return 16'($signed($urandom_range(600)) - 300);
		if (c < 90) return 16'($urandom);
		return c[0] ? 16'h7FFF : 16'h8000;
	endfunction

	function automatic logic [15:0] rand_acc();
		int c;
		c = $urandom_range(99);
		if (c < 20) return 16'd0;
		if (c < 30) return 16'd1;
		if (c < 40) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	task automatic random_config();
		logic [63:0] w;
		int c;
		for (int sp = 0; sp < 4; sp++) begin
			c = $urandom_range(9);
			if (c == 0) w = '0;
			else if (c == 1) w = '1;
			else w = {$urandom, $urandom};
			set_species(sp, $signed($urandom_range(8)) - 4, w, {$urandom, $urandom});
		end
		n_settings++;
	endtask

	task automatic random_grid();
		int len;
		len = $urandom_range(6, 1);
		for (int i = 0; i < len; i++)
			send_point(rand_pot(), rand_acc(), i == len - 1);
	endtask

	initial begin
		int target;
		arst_n        = 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		point.valid   <= 1'b0;
		point.potential     <= '0;
		point.accessibility <= '0;
		point.last_point    <= 1'b0;
		hold_req      = 1'b0;
		snd_idle      = 0;
		rcv_stall     = 0;
		n_points      = 0;
		n_grids       = 0;
		n_settings    = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, inaccessible last point
		send_point(16'h0100, 16'h0001, 1'b0);
		send_point(16'hFF00, 16'h0000, 1'b1);
		drain();

		// extreme valences and full weights on species 0 and 1
		set_species(0, 4, '1, '1);
		set_species(1, -4, '1, '0);
		set_species(2, -1, 64'h00_8000_0000, {$urandom, $urandom});
		set_species(3, 0, 64'd1, '1);
		n_settings++;
		send_point(16'h7FFF, 16'hFFFF, 1'b0);
		send_point(16'h8000, 16'h0001, 1'b0);
		send_point(16'h0000, 16'h8000, 1'b0);
		send_point(16'h0001, 16'h0001, 1'b0);
		send_point(16'hFFFF, 16'h0002, 1'b0);
		send_point(16'h0400, 16'h0001, 1'b0);
		send_point(16'hFC00, 16'h0001, 1'b1);
		send_point(16'h5555, 16'hAAAA, 1'b1);
		send_point(16'h1234, 16'h0000, 1'b1);
		drain();

		// zero weights, zero valences
		for (int sp = 0; sp < 4; sp++)
			set_species(sp, 0, '0, '1);
		n_settings++;
		send_point(16'h2AAA, 16'h5555, 1'b0);
		send_point(16'hD555, 16'h0001, 1'b1);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			snd_idle  = (ph == 0) ? 17 : (ph == 1) ? 88 : 0;
			rcv_stall = (ph == 0) ? 88 : (ph == 1) ? 17 : 0;
			random_config();
			if (ph == 2) hold_req = 1'b1;
			target = n_points + 50;
			while (n_points < target) begin
				random_grid();
				if ($urandom_range(3) == 0) begin
					drain();
					random_config();
				end
			end
			drain();
		end

		$display("covered %0d points in %0d grids, %0d results checked, %0d register settings",
			n_points, n_grids, checked, n_settings);
		$display("handshake mixes: slow sink, slow source, full rate with a long sink hold-off");
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
